@@ rtl/lrud_pkg.sv @@
// shared types, constants and directory functions for the two-level lru directory
package lrud_pkg;

  // geometry limits of the directory rows
  localparam int SLOTS       = 16;
  localparam int L1_ROWS     = 64;
  localparam int L2_ROWS     = 256;
  localparam int L1_ROW_W    = 6;
  localparam int L2_ROW_W    = 8;
  localparam logic [3:0] L1_LINES_LOG2 = 4'd10;
  localparam logic [3:0] L2_LINES_LOG2 = 4'd12;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // served level codes
  localparam logic [1:0] SERVED_L1  = 2'd0;
  localparam logic [1:0] SERVED_L2  = 2'd1;
  localparam logic [1:0] SERVED_MEM = 2'd2;

  // directory passes
  localparam logic [1:0] OP_L1_MAIN  = 2'd0;
  localparam logic [1:0] OP_L2_TOUCH = 2'd1;
  localparam logic [1:0] OP_L2_MAIN  = 2'd2;
  localparam logic [1:0] OP_L1_INV   = 2'd3;

  // row update kinds
  localparam logic [1:0] KIND_MAIN  = 2'd0;
  localparam logic [1:0] KIND_TOUCH = 2'd1;
  localparam logic [1:0] KIND_INV   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_BLOCK_LOG2 = 3'd0;
  localparam logic [2:0] REG_L1_SIZE    = 3'd1;
  localparam logic [2:0] REG_L1_WAYS    = 3'd2;
  localparam logic [2:0] REG_L2_SIZE    = 3'd3;
  localparam logic [2:0] REG_L2_WAYS    = 3'd4;
  localparam logic [2:0] REG_WRITE_ALLOC = 3'd5;

  typedef struct packed {
    logic [31:0] tag;
    logic        vld;
    logic        drt;
    logic [3:0]  rnk;
  } slot_t;

  typedef slot_t [SLOTS-1:0] row_t;

  typedef struct packed {
    logic [3:0] block_log2;
    logic [4:0] l1_size_log2;
    logic [2:0] l1_ways_log2;
    logic [4:0] l2_size_log2;
    logic [2:0] l2_ways_log2;
    logic       alloc_on_write;
  } cfg_t;

  typedef struct packed {
    logic [11:0] line;
    logic [31:0] blk;
    logic [2:0]  wl;
  } loc_t;

  typedef struct packed {
    row_t        row;
    logic        hit;
    logic        vv;
    logic        vd;
    logic [31:0] vb;
  } proc_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       clear;
    logic       rd;
    logic       ex;
    logic       done;
    logic [1:0] op;
    logic [7:0] clr_row;
  } lrud_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic victim;
    logic victim_dirty;
    logic out_free;
  } lrud_status_t;

  // set position and block address of an address at one level
  function automatic loc_t lrud_locate(logic [31:0] addr, logic [3:0] b,
                                       logic [4:0] size, logic [2:0] wsel,
                                       logic [3:0] lim);
    logic [2:0]        wl;
    logic signed [6:0] diff;
    logic [4:0]        sl;
    logic [4:0]        cap;
    logic [11:0]       mask;
    logic [31:0]       sh;
    logic [11:0]       set;
    loc_t              l;
    wl = (wsel > 3'd4) ? 3'd4 : wsel;
    diff = $signed({2'b0, size}) - $signed({3'b0, b}) - $signed({4'b0, wl});
    sl = diff[6] ? 5'd0 : diff[4:0];
    cap = {1'b0, lim} - {2'b0, wl};
    if (sl > cap) sl = cap;
    mask = ~(12'hfff << sl);
    sh = addr >> b;
    set = sh[11:0] & mask;
    l.line = set << wl;
    l.blk = addr & (32'hffffffff << b);
    l.wl = wl;
    return l;
  endfunction

  // lookup, fill, touch or invalidate inside one directory row
  function automatic proc_t lrud_proc(row_t row, logic [3:0] off, logic [2:0] wl,
                                      logic [31:0] blk, logic [1:0] kind,
                                      logic wr, logic alloc);
    proc_t       r;
    logic [3:0]  wmask;
    logic [15:0] mem;
    logic [15:0] hitv;
    logic [15:0] inv;
    logic [15:0] minv;
    logic [3:0]  hs;
    logic [3:0]  is;
    logic [3:0]  ms;
    logic [3:0]  tgt;
    logic [3:0]  prev;
    logic        do_touch;
    wmask = 4'((5'd1 << wl) - 5'd1);
    // set membership and per slot flags
    for (int s = 0; s < SLOTS; s++) begin
      mem[s]  = ((4'(s) & ~wmask) == (off & ~wmask));
      hitv[s] = mem[s] && row[s].vld && (row[s].tag == blk);
      inv[s]  = mem[s] && !row[s].vld;
    end
    // first lowest rank by pairwise compare
    for (int s = 0; s < SLOTS; s++) begin
      minv[s] = mem[s];
      for (int j = 0; j < SLOTS; j++) begin
        if (mem[j] && j < s && !(row[s].rnk < row[j].rnk)) minv[s] = 1'b0;
        if (mem[j] && j > s && !(row[s].rnk <= row[j].rnk)) minv[s] = 1'b0;
      end
    end
    hs = 4'd0;
    is = 4'd0;
    ms = 4'd0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (hitv[s]) hs = 4'(s);
      if (inv[s]) is = 4'(s);
      if (minv[s]) ms = 4'(s);
    end
    r.row = row;
    r.hit = |hitv;
    r.vv = 1'b0;
    r.vd = 1'b0;
    r.vb = 32'd0;
    do_touch = 1'b0;
    tgt = hs;
    case (kind)
      KIND_MAIN: begin
        if (r.hit) begin
          do_touch = 1'b1;
          if (wr) r.row[hs].drt = 1'b1;
        end else if (alloc) begin
          tgt = (|inv) ? is : ms;
          if (!(|inv)) begin
            r.vv = 1'b1;
            r.vd = row[ms].drt;
            r.vb = row[ms].tag;
          end
          r.row[tgt].tag = blk;
          r.row[tgt].vld = 1'b1;
          r.row[tgt].drt = wr;
          do_touch = 1'b1;
        end
      end
      KIND_TOUCH: begin
        if (r.hit) begin
          do_touch = 1'b1;
          r.row[hs].drt = 1'b1;
        end
      end
      KIND_INV: begin
        if (r.hit) begin
          r.row[hs].vld = 1'b0;
          r.row[hs].drt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    // lru update around the touched way
    prev = row[tgt].rnk;
    if (do_touch) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (4'(s) == tgt) r.row[s].rnk = wmask;
        else if (mem[s] && r.row[s].vld && row[s].rnk > prev)
          r.row[s].rnk = row[s].rnk - 4'd1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/lrud_ctrl.sv @@
// pass sequencer for the two-level lru directory
module lrud_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lrud_pkg::lrud_status_t st,
  output lrud_pkg::lrud_cmd_t    cmd
);
  import lrud_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] op, op_next;
  logic [7:0] clr_row;

  // next state and commands
  always_comb begin
    state_next = state;
    op_next = op;
    cmd = '0;
    cmd.op = op;
    cmd.clr_row = clr_row;
    unique case (state)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (clr_row == 8'(L2_ROWS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          op_next = OP_L1_MAIN;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_EX;
      end
      S_EX: begin
        cmd.ex = 1'b1;
        state_next = S_RD;
        unique case (op)
          OP_L1_MAIN: begin
            if (st.hit) state_next = S_DONE;
            else if (st.victim && st.victim_dirty) op_next = OP_L2_TOUCH;
            else op_next = OP_L2_MAIN;
          end
          OP_L2_TOUCH: op_next = OP_L2_MAIN;
          OP_L2_MAIN: begin
            if (st.victim) op_next = OP_L1_INV;
            else state_next = S_DONE;
          end
          OP_L1_INV: state_next = S_DONE;
          default: state_next = S_DONE;
        endcase
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // state, pass and clearing row
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      op <= OP_L1_MAIN;
      clr_row <= 8'd0;
    end else begin
      state <= state_next;
      op <= op_next;
      if (state == S_CLR) clr_row <= clr_row + 8'd1;
    end
  end

  // sequencing checks
  a_load_rd: assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.rd)
    else $error("load not followed by row read");
  a_rd_ex: assert property (@(posedge clk) disable iff (rst) cmd.rd |=> cmd.ex)
    else $error("row read not followed by update");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    cmd.done |-> ($past(cmd.ex) || $past(state == S_DONE)))
    else $error("result without a finished pass");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.clear, cmd.rd, cmd.ex, cmd.done}))
    else $error("conflicting commands");

endmodule

@@ rtl/lrud_datapath.sv @@
// directory rows, row update logic, counters and result register
module lrud_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  lrud_pkg::cfg_t         cfg,
  input  lrud_pkg::lrud_cmd_t    cmd,
  output lrud_pkg::lrud_status_t st,
  input  logic                   cmd_in,
  input  logic [31:0]            address,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             served_level,
  output logic                   l1_victim_valid,
  output logic                   l1_victim_dirty,
  output logic [31:0]            l1_victim_block,
  output logic                   l2_victim_valid,
  output logic [31:0]            l2_victim_block,
  output logic [31:0]            l1_accesses,
  output logic [31:0]            l1_misses,
  output logic [31:0]            l2_accesses,
  output logic [31:0]            l2_misses
);
  import lrud_pkg::*;

  row_t l1_mem [L1_ROWS];
  row_t l2_mem [L2_ROWS];
  row_t l1_q, l2_q;

  logic        item_wr;
  logic [31:0] item_addr;
  logic        v1, d1, v2;
  logic [31:0] b1, b2;
  logic [1:0]  served;
  logic [31:0] l1_acc, l1_miss, l2_acc, l2_miss;

  logic        lvl1;
  logic [31:0] look_addr;
  logic [1:0]  kind;
  loc_t        loc;
  proc_t       res;
  logic [L1_ROW_W-1:0] l1_row;
  logic [L2_ROW_W-1:0] l2_row;

  // pass decode: level, address and update kind
  always_comb begin
    lvl1 = 1'b1;
    look_addr = item_addr;
    kind = KIND_MAIN;
    case (cmd.op)
      OP_L1_MAIN: begin
        lvl1 = 1'b1;
      end
      OP_L2_TOUCH: begin
        lvl1 = 1'b0;
        look_addr = b1;
        kind = KIND_TOUCH;
      end
      OP_L2_MAIN: begin
        lvl1 = 1'b0;
      end
      OP_L1_INV: begin
        look_addr = b2;
        kind = KIND_INV;
      end
      default: begin
      end
    endcase
  end

  // locate and update the selected row
  always_comb begin
    if (lvl1)
      loc = lrud_locate(look_addr, cfg.block_log2, cfg.l1_size_log2,
                        cfg.l1_ways_log2, L1_LINES_LOG2);
    else
      loc = lrud_locate(look_addr, cfg.block_log2, cfg.l2_size_log2,
                        cfg.l2_ways_log2, L2_LINES_LOG2);
    res = lrud_proc(lvl1 ? l1_q : l2_q, loc.line[3:0], loc.wl, loc.blk, kind,
                    item_wr, !item_wr || cfg.alloc_on_write);
  end

  assign l1_row = loc.line[9:4];
  assign l2_row = loc.line[11:4];

  assign st.hit = res.hit;
  assign st.victim = res.vv;
  assign st.victim_dirty = res.vd;
  assign st.out_free = !out_valid || !out_stall;

  // first level rows
  always_ff @(posedge clk) begin
    if (cmd.clear && cmd.clr_row[7:6] == 2'd0) l1_mem[cmd.clr_row[5:0]] <= '0;
    else if (cmd.ex && lvl1) l1_mem[l1_row] <= res.row;
    if (cmd.rd) l1_q <= l1_mem[l1_row];
  end

  // second level rows
  always_ff @(posedge clk) begin
    if (cmd.clear) l2_mem[cmd.clr_row] <= '0;
    else if (cmd.ex && !lvl1) l2_mem[l2_row] <= res.row;
    if (cmd.rd) l2_q <= l2_mem[l2_row];
  end

  // item, victims and serving level
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_wr <= cmd_in;
      item_addr <= address;
      v1 <= 1'b0;
      d1 <= 1'b0;
      b1 <= 32'd0;
      v2 <= 1'b0;
      b2 <= 32'd0;
      served <= SERVED_L1;
    end else if (cmd.ex && cmd.op == OP_L1_MAIN) begin
      v1 <= res.vv;
      d1 <= res.vd;
      b1 <= res.vb;
      if (!res.hit) served <= SERVED_L2;
    end else if (cmd.ex && cmd.op == OP_L2_MAIN) begin
      v2 <= res.vv;
      b2 <= res.vb;
      if (!res.hit) served <= SERVED_MEM;
    end
  end

  // running counters
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_acc <= 32'd0;
      l1_miss <= 32'd0;
      l2_acc <= 32'd0;
      l2_miss <= 32'd0;
    end else begin
      if (cmd.load) l1_acc <= l1_acc + 32'd1;
      if (cmd.ex && cmd.op == OP_L1_MAIN && !res.hit) begin
        l1_miss <= l1_miss + 32'd1;
        l2_acc <= l2_acc + 32'd1;
      end
      if (cmd.ex && cmd.op == OP_L2_MAIN && !res.hit) l2_miss <= l2_miss + 32'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      served_level <= served;
      l1_victim_valid <= v1;
      l1_victim_dirty <= d1;
      l1_victim_block <= b1;
      l2_victim_valid <= v2;
      l2_victim_block <= b2;
      l1_accesses <= l1_acc;
      l1_misses <= l1_miss;
      l2_accesses <= l2_acc;
      l2_misses <= l2_miss;
    end
  end

endmodule

@@ rtl/two_level_lru_cache_directory.sv @@
// Two-level set-associative lru tag directory. Every access makes a first level
// pass; every further directory pass (second level lookup, touch of the second
// level copy of a dirty first level victim, invalidation of the first level copy
// of a second level victim) is likewise a registered row read followed by a row
// update and write back. A finished result waits for the result register to be
// free, and in_stall holds off the next access until the result has been
// written into that register. Both levels are single-port row memories whose
// rows hold 16 lines, 64 rows for the first level and 256 for the second, and
// every pass goes through them in turn. After reset a clearing pass walks the
// rows, during which in_stall is high; register writes are taken at any time
// and must only be made while the block is idle.
module two_level_lru_cache_directory (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  served_level,
  output logic        l1_victim_valid,
  output logic        l1_victim_dirty,
  output logic [31:0] l1_victim_block,
  output logic        l2_victim_valid,
  output logic [31:0] l2_victim_block,
  output logic [31:0] l1_accesses,
  output logic [31:0] l1_misses,
  output logic [31:0] l2_accesses,
  output logic [31:0] l2_misses,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import lrud_pkg::*;

  cfg_t         cfg;
  lrud_cmd_t    ctl;
  lrud_status_t st;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_log2 <= 4'd4;
      cfg.l1_size_log2 <= 5'd10;
      cfg.l1_ways_log2 <= 3'd1;
      cfg.l2_size_log2 <= 5'd12;
      cfg.l2_ways_log2 <= 3'd2;
      cfg.alloc_on_write <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_LOG2:  cfg.block_log2 <= cfg_data[3:0];
        REG_L1_SIZE:     cfg.l1_size_log2 <= cfg_data;
        REG_L1_WAYS:     cfg.l1_ways_log2 <= cfg_data[2:0];
        REG_L2_SIZE:     cfg.l2_size_log2 <= cfg_data;
        REG_L2_WAYS:     cfg.l2_ways_log2 <= cfg_data[2:0];
        REG_WRITE_ALLOC: cfg.alloc_on_write <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lrud_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (ctl)
  );

  lrud_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (ctl),
    .st              (st),
    .cmd_in          (cmd),
    .address         (address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .served_level    (served_level),
    .l1_victim_valid (l1_victim_valid),
    .l1_victim_dirty (l1_victim_dirty),
    .l1_victim_block (l1_victim_block),
    .l2_victim_valid (l2_victim_valid),
    .l2_victim_block (l2_victim_block),
    .l1_accesses     (l1_accesses),
    .l1_misses       (l1_misses),
    .l2_accesses     (l2_accesses),
    .l2_misses       (l2_misses)
  );

endmodule

@@ tb/tb_two_level_lru_cache_directory.sv @@
// self-checking testbench for the two-level lru cache directory
module tb_two_level_lru_cache_directory;
  timeunit 1ns;
  timeprecision 1ps;
  import lrud_pkg::*;

  typedef struct {
    logic [1:0]  served;
    logic        v1;
    logic        d1;
    logic [31:0] b1;
    logic        v2;
    logic [31:0] b2;
    logic [31:0] l1a;
    logic [31:0] l1m;
    logic [31:0] l2a;
    logic [31:0] l2m;
  } access_res_t;

  typedef struct {
    logic        wr;
    logic [31:0] addr;
    bit          typed;
    logic [1:0]  served;
    logic [31:0] l1a;
    logic [31:0] l1m;
    logic [31:0] l2a;
    logic [31:0] l2m;
  } access_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_READ;
  logic [31:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  served_level;
  logic        l1_victim_valid, l1_victim_dirty, l2_victim_valid;
  logic [31:0] l1_victim_block, l2_victim_block;
  logic [31:0] l1_accesses, l1_misses, l2_accesses, l2_misses;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  two_level_lru_cache_directory dut (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // directory shadow: level 0 is l1, level 1 is l2
  logic [31:0] sh_tag [0:1][0:4095];
  logic        sh_vld [0:1][0:4095];
  logic        sh_drt [0:1][0:4095];
  logic [3:0]  sh_rnk [0:1][0:4095];
  logic [31:0] n_l1a, n_l1m, n_l2a, n_l2m;
  int unsigned g_blk, g_size [0:1], g_ways [0:1], g_walloc;

  access_res_t expected_q [$];
  int  n_errors = 0;
  int  n_results = 0;
  int  n_accepted = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;

  task automatic report(string field, logic [31:0] got, logic [31:0] exp);
    $display("mismatch on %s at result %0d: got %h expected %h", field, n_results, got, exp);
    n_errors++;
  endtask

  // set position of an address under the current geometry
  function automatic void locate_set(int lv, logic [31:0] a, output int ways,
                                     output int base, output logic [31:0] blk);
    int limit, wl, sl;
    limit = lv ? 4096 : 1024;
    wl = g_ways[lv];
    while (wl > 0 && ((1 << wl) > 16 || (1 << wl) > limit)) wl--;
    sl = int'(g_size[lv]) - int'(g_blk) - wl;
    if (sl < 0) sl = 0;
    while (sl > 0 && (longint'(1) << (sl + wl)) > limit) sl--;
    ways = 1 << wl;
    base = int'((a >> g_blk) & ((32'd1 << sl) - 1)) * ways;
    blk = a & ~((32'd1 << g_blk) - 1);
  endfunction

  function automatic int find_line(int lv, int ways, int base, logic [31:0] blk);
    for (int i = 0; i < ways; i++)
      if (sh_vld[lv][base+i] && sh_tag[lv][base+i] == blk) return i;
    return -1;
  endfunction

  function automatic void make_recent(int lv, int ways, int base, int way);
    logic [3:0] prev;
    prev = sh_rnk[lv][base+way];
    sh_rnk[lv][base+way] = 4'(ways - 1);
    for (int i = 0; i < ways; i++)
      if (i != way && sh_vld[lv][base+i] && sh_rnk[lv][base+i] > prev)
        sh_rnk[lv][base+i]--;
  endfunction

  function automatic void fill_line(int lv, int ways, int base, logic [31:0] blk, logic wr,
                                    output logic vv, output logic vd, output logic [31:0] vb);
    int way;
    bit found;
    logic [3:0] best;
    way = 0;
    found = 1'b0;
    vv = 1'b0; vd = 1'b0; vb = '0;
    for (int i = 0; i < ways && !found; i++)
      if (!sh_vld[lv][base+i]) begin
        way = i;
        found = 1'b1;
      end
    if (!found) begin
      best = sh_rnk[lv][base];
      for (int i = 1; i < ways; i++)
        if (sh_rnk[lv][base+i] < best) begin
          best = sh_rnk[lv][base+i];
          way = i;
        end
      vv = 1'b1;
      vd = sh_drt[lv][base+way];
      vb = sh_tag[lv][base+way];
    end
    sh_tag[lv][base+way] = blk;
    sh_vld[lv][base+way] = 1'b1;
    sh_drt[lv][base+way] = wr;
    make_recent(lv, ways, base, way);
  endfunction

  // one access through both levels
  function automatic access_res_t lookup_access(logic wr, logic [31:0] a);
    access_res_t r;
    int ways, base, way, vw, vb, vway;
    logic [31:0] blk, vblk;
    logic d2;
    r = '{default: '0};
    r.served = SERVED_L1;
    n_l1a++;
    locate_set(0, a, ways, base, blk);
    way = find_line(0, ways, base, blk);
    if (way >= 0) begin
      make_recent(0, ways, base, way);
      if (wr) sh_drt[0][base+way] = 1'b1;
    end else begin
      n_l1m++;
      if (!wr || g_walloc) fill_line(0, ways, base, blk, wr, r.v1, r.d1, r.b1);
      // dirty l1 victim refreshes its l2 copy
      if (r.v1 && r.d1) begin
        locate_set(1, r.b1, vw, vb, vblk);
        vway = find_line(1, vw, vb, vblk);
        if (vway >= 0) begin
          make_recent(1, vw, vb, vway);
          sh_drt[1][vb+vway] = 1'b1;
        end
      end
      r.served = SERVED_L2;
      n_l2a++;
      locate_set(1, a, ways, base, blk);
      way = find_line(1, ways, base, blk);
      if (way >= 0) begin
        make_recent(1, ways, base, way);
        if (wr) sh_drt[1][base+way] = 1'b1;
      end else begin
        n_l2m++;
        r.served = SERVED_MEM;
        if (!wr || g_walloc) fill_line(1, ways, base, blk, wr, r.v2, d2, r.b2);
        // l2 victim drops its l1 copy
        if (r.v2) begin
          locate_set(0, r.b2, vw, vb, vblk);
          vway = find_line(0, vw, vb, vblk);
          if (vway >= 0) begin
            sh_vld[0][vb+vway] = 1'b0;
            sh_drt[0][vb+vway] = 1'b0;
          end
        end
      end
    end
    r.l1a = n_l1a; r.l1m = n_l1m; r.l2a = n_l2a; r.l2m = n_l2m;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    access_res_t e;
    if (out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report("unexpected result beat", 32'(n_results), 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (served_level !== e.served)
          report("served_level", 32'(served_level), 32'(e.served));
        if (l1_victim_valid !== e.v1)
          report("l1_victim_valid", 32'(l1_victim_valid), 32'(e.v1));
        if (l1_victim_dirty !== e.d1)
          report("l1_victim_dirty", 32'(l1_victim_dirty), 32'(e.d1));
        if (l1_victim_block !== e.b1) report("l1_victim_block", l1_victim_block, e.b1);
        if (l2_victim_valid !== e.v2)
          report("l2_victim_valid", 32'(l2_victim_valid), 32'(e.v2));
        if (l2_victim_block !== e.b2) report("l2_victim_block", l2_victim_block, e.b2);
        if (l1_accesses !== e.l1a) report("l1_accesses", l1_accesses, e.l1a);
        if (l1_misses !== e.l1m) report("l1_misses", l1_misses, e.l1m);
        if (l2_accesses !== e.l2a) report("l2_accesses", l2_accesses, e.l2a);
        if (l2_misses !== e.l2m) report("l2_misses", l2_misses, e.l2m);
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 36);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= 4000) begin
      $display("simulation failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // one access beat; expectation pushed at acceptance
  task automatic send_access(logic wr, logic [31:0] a, bit typed, access_res_t typed_res);
    int gap;
    access_res_t r;
    if (!quiet && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= wr;
    address <= a;
    do @(posedge clk); while (in_stall);
    n_accepted++;
    r = lookup_access(wr, a);
    if (typed) begin
      r.served = typed_res.served;
      r.l1a = typed_res.l1a; r.l1m = typed_res.l1m;
      r.l2a = typed_res.l2a; r.l2m = typed_res.l2m;
    end
    expected_q.push_back(r);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BLOCK_LOG2:  g_blk = val & 15;
      REG_L1_SIZE:     g_size[0] = val;
      REG_L1_WAYS:     g_ways[0] = val & 7;
      REG_L2_SIZE:     g_size[1] = val;
      REG_L2_WAYS:     g_ways[1] = val & 7;
      REG_WRITE_ALLOC: g_walloc = val & 1;
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic set_geometry(int b, int s1, int w1, int s2, int w2, int wa);
    drain();
    write_reg(REG_BLOCK_LOG2, 5'(b));
    write_reg(REG_L1_SIZE, 5'(s1));
    write_reg(REG_L1_WAYS, 5'(w1));
    write_reg(REG_L2_SIZE, 5'(s2));
    write_reg(REG_L2_WAYS, 5'(w2));
    write_reg(REG_WRITE_ALLOC, 5'(wa));
  endtask

  // random accesses mostly over a small pool of conflicting blocks
  task automatic random_burst(int count);
    logic [31:0] hi [4];
    logic [31:0] pool [32];
    logic [31:0] a;
    access_res_t none;
    none = '{default: '0};
    foreach (hi[i]) hi[i] = $urandom & 32'hffff_f000;
    foreach (pool[i])
      pool[i] = hi[$urandom_range(0, 3)] | ($urandom_range(0, 15) << 8) | $urandom_range(0, 255);
    for (int i = 0; i < count; i++) begin
      a = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 31)] : $urandom;
      send_access(1'($urandom_range(0, 1)), a, 1'b0, none);
    end
  endtask

  access_row_t directed [17] = '{
    '{CMD_READ,  32'h0000_0000, 1, SERVED_MEM, 1, 1, 1, 1},
    '{CMD_READ,  32'h0000_0000, 1, SERVED_L1,  2, 1, 1, 1},
    '{CMD_WRITE, 32'h0000_0000, 1, SERVED_L1,  3, 1, 1, 1},
    '{CMD_READ,  32'hffff_ffff, 1, SERVED_MEM, 4, 2, 2, 2},
    '{CMD_WRITE, 32'h0000_0200, 0, 0, 0, 0, 0, 0},
    '{CMD_READ,  32'h0000_0400, 0, 0, 0, 0, 0, 0},
    '{CMD_READ,  32'h0000_000f, 0, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 32'h0000_0800, 0, 0, 0, 0, 0, 0},
    '{CMD_READ,  32'h0000_0c00, 0, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 32'h0000_1000, 0, 0, 0, 0, 0, 0},
    '{CMD_READ,  32'h0000_1400, 0, 0, 0, 0, 0, 0},
    '{CMD_READ,  32'h0000_0200, 0, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 32'hffff_fff0, 0, 0, 0, 0, 0, 0},
    '{CMD_READ,  32'h8000_0000, 0, 0, 0, 0, 0, 0},
    '{CMD_WRITE, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0},
    '{CMD_READ,  32'h0000_1800, 0, 0, 0, 0, 0, 0},
    '{CMD_READ,  32'h0000_0000, 0, 0, 0, 0, 0, 0}
  };

  // stimulus
  initial begin
    access_res_t typed_res;
    g_blk = 4; g_size[0] = 10; g_ways[0] = 1; g_size[1] = 12; g_ways[1] = 2; g_walloc = 1;
    n_l1a = '0; n_l1m = '0; n_l2a = '0; n_l2m = '0;
    for (int l = 0; l < 2; l++)
      for (int i = 0; i < 4096; i++) begin
        sh_vld[l][i] = 1'b0; sh_drt[l][i] = 1'b0; sh_rnk[l][i] = '0;
      end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed accesses under the reset geometry
    foreach (directed[i]) begin
      typed_res = '{default: '0};
      typed_res.served = directed[i].served;
      typed_res.l1a = directed[i].l1a; typed_res.l1m = directed[i].l1m;
      typed_res.l2a = directed[i].l2a; typed_res.l2m = directed[i].l2m;
      send_access(directed[i].wr, directed[i].addr, directed[i].typed, typed_res);
    end
    // unused register indexes, then a write miss without allocation
    set_geometry(4, 10, 1, 12, 2, 0);
    write_reg(3'd6, 5'd31);
    write_reg(3'd7, 5'd0);
    typed_res = '{default: '0};
    send_access(CMD_WRITE, 32'h0001_0000, 1'b0, typed_res);
    send_access(CMD_READ, 32'h0001_0000, 1'b0, typed_res);

    // random phases over several geometries, extremes included
    quiet = 1'b1;
    random_burst(200);
    quiet = 1'b0;
    set_geometry(2, 2, 0, 2, 0, 0);
    random_burst(150);
    set_geometry(8, 18, 4, 20, 4, 1);
    hold_req = 1'b1;
    random_burst(200);
    set_geometry(15, 31, 7, 31, 7, 1);
    random_burst(150);
    set_geometry(0, 0, 0, 0, 0, 1);
    random_burst(150);
    set_geometry(4, 10, 1, 12, 2, 1);
    random_burst(200);
    for (int p = 0; p < 5; p++) begin
      set_geometry($urandom_range(2, 8), $urandom_range(2, 18), $urandom_range(0, 4),
                   $urandom_range(2, 20), $urandom_range(0, 4), $urandom_range(0, 1));
      random_burst(150);
    end
    drain();

    $display("ran %0d accesses and checked %0d results over eleven geometries,", n_accepted,
             n_results);
    $display("with write allocation on and off and a long output hold-off");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
